// ===== sv/quoted_string_escaper_defines.svh =====
`ifndef QUOTED_STRING_ESCAPER_DEFINES_SVH
`define QUOTED_STRING_ESCAPER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define QSE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define QSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/qse_pkg.sv =====
`default_nettype none

package qse_pkg;

  localparam int unsigned SEQ_MAX    = 6;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_BEL      = 8'h07;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LC_N     = 8'h6E;
  localparam logic [7:0] CH_LC_R     = 8'h72;
  localparam logic [7:0] CH_LC_T     = 8'h74;
  localparam logic [7:0] CH_LC_A     = 8'h61;
  localparam logic [7:0] CH_LC_B     = 8'h62;
  localparam logic [7:0] CH_LC_X     = 8'h78;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] seq;
    logic [LEN_W-1:0]        len;
  } qse_rec_t;

  typedef struct packed {
    logic [LEN_W-1:0] idx;
    logic             mid_rec;
  } qse_back_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_DIGIT_0 + {4'b0000, nib};
    end else begin
      return CH_LC_A + {4'b0000, nib} - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/qse_front.sv =====
`default_nettype none

module qse_front
  import qse_pkg::*;
(
  input  wire logic [7:0] char_in,
  input  wire logic       is_first,
  input  wire logic       is_last,
  input  wire logic       no_char,
  output qse_rec_t        rec,
  output logic            has_out
);

  logic [3:0][7:0]  esc;
  logic [LEN_W-1:0] esc_len;
  logic [LEN_W-1:0] n;
  logic [LEN_W-1:0] pos;

  always_comb begin
    esc     = '0;
    esc_len = LEN_W'(2);
    case (char_in)
      CH_BSLASH, CH_QUOTE: begin
        esc[0] = CH_BSLASH;
        esc[1] = char_in;
      end
      CH_NL: begin
        esc[0] = CH_BSLASH;
        esc[1] = CH_LC_N;
      end
      CH_CR: begin
        esc[0] = CH_BSLASH;
        esc[1] = CH_LC_R;
      end
      CH_TAB: begin
        esc[0] = CH_BSLASH;
        esc[1] = CH_LC_T;
      end
      CH_BEL: begin
        esc[0] = CH_BSLASH;
        esc[1] = CH_LC_A;
      end
      CH_BS: begin
        esc[0] = CH_BSLASH;
        esc[1] = CH_LC_B;
      end
      default: begin
        if (char_in >= CH_PRINT_LO && char_in <= CH_PRINT_HI) begin
          esc[0]  = char_in;
          esc_len = LEN_W'(1);
        end else begin
          esc[0]  = CH_BSLASH;
          esc[1]  = CH_LC_X;
          esc[2]  = hex_char(char_in[7:4]);
          esc[3]  = hex_char(char_in[3:0]);
          esc_len = LEN_W'(4);
        end
      end
    endcase
  end

  always_comb begin
    rec = '0;
    n   = '0;
    pos = '0;
    if (is_first) begin
      rec.seq[0] = CH_QUOTE;
      n          = LEN_W'(1);
    end
    if (!no_char) begin
      for (int k = 0; k < 4; k++) begin
        pos = n + LEN_W'(k);
        if (LEN_W'(k) < esc_len) begin
          rec.seq[pos] = esc[k];
        end
      end
      n = n + esc_len;
    end
    if (is_last) begin
      rec.seq[n] = CH_QUOTE;
      n          = n + LEN_W'(1);
    end
    rec.len = n;
    has_out = (n != '0);
  end

endmodule

`default_nettype wire

// ===== sv/qse_fifo.sv =====
`default_nettype none

module qse_fifo
  import qse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire qse_rec_t   wr_rec,
  input  wire logic       rd_en,
  output qse_rec_t        rd_rec,
  output logic            full,
  output logic            empty,
  output logic [CNT_W-1:0] count
);

  qse_rec_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full   = (count_r == CNT_W'(FIFO_DEPTH));
  assign empty  = (count_r == '0);
  assign count  = count_r;
  assign rd_rec = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

`default_nettype wire

// ===== sv/qse_back.sv =====
`default_nettype none

module qse_back
  import qse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire qse_rec_t   head_rec,
  input  wire logic       head_valid,
  output logic            pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  output qse_back_stat_t  stat
);

  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r;
  logic             out_last_r;
  logic             load;
  logic             at_end;

  assign load   = !out_valid_r || out_tready;
  assign at_end = (idx_r == head_rec.len - LEN_W'(1));

  always_comb begin
    idx_nxt       = idx_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    if (load && head_valid) begin
      out_valid_nxt = 1'b1;
      if (at_end) begin
        idx_nxt = '0;
        pop     = 1'b1;
      end else begin
        idx_nxt = idx_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_data_r <= head_rec.seq[idx_r];
      out_last_r <= at_end;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign stat.idx     = idx_r;
  assign stat.mid_rec = (idx_r != '0);

endmodule

`default_nettype wire

// ===== sv/quoted_string_escaper.sv =====
// Channel   Direction  tdata        tuser                    tlast
// in_       slave      char_in      [0] is_first [1] no_char  is_last
// out_      master     out_byte     (none)                   last_of_run
//
// Each item yields 0 to 6 output bytes, one for plain text.
// The output register emits one byte a cycle while out_tready is high and sets the sustained rate.
// A four-entry item queue sits between the classifier and the emitter.
// An accepted item is written into the queue, then its first byte is loaded into the output register.
// Synchronous reset empties the queue and clears the output valid flag.
// in_tready drops only while the queue is full.
`default_nettype none
`include "quoted_string_escaper_defines.svh"

module quoted_string_escaper
  import qse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_in
  input  wire logic [1:0] in_tuser,   // [0] is_first, [1] no_char
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast
);

  qse_rec_t         front_rec;
  qse_rec_t         head_rec;
  logic             has_out;
  logic             wr_en;
  logic             pop;
  logic             fifo_full;
  logic             fifo_empty;
  logic [CNT_W-1:0] fifo_count;
  qse_back_stat_t   stat;

  qse_front u_front (
    .char_in  (in_tdata),
    .is_first (in_tuser[0]),
    .is_last  (in_tlast),
    .no_char  (in_tuser[1]),
    .rec      (front_rec),
    .has_out  (has_out)
  );

  assign in_tready = !fifo_full;
  assign wr_en     = in_tvalid && in_tready && has_out;

  qse_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_rec (front_rec),
    .rd_en  (pop),
    .rd_rec (head_rec),
    .full   (fifo_full),
    .empty  (fifo_empty),
    .count  (fifo_count)
  );

  qse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_rec   (head_rec),
    .head_valid (!fifo_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .stat       (stat)
  );

  `QSE_ASSERT_ALWAYS(a_fifo_bound, fifo_count <= CNT_W'(FIFO_DEPTH), "queue overflow")
  `QSE_ASSERT_ALWAYS(a_head_index, fifo_empty || (head_rec.len != '0 && stat.idx < head_rec.len), "bad emit index")
  `QSE_ASSERT_ALWAYS(a_mid_needs_head, !stat.mid_rec || !fifo_empty, "partial item without queue head")
  `QSE_ASSERT_NEXT(a_pop_drains, pop && !wr_en, fifo_count == $past(fifo_count) - CNT_W'(1), "pop lost")

endmodule

`default_nettype wire

// ===== tb/tb_quoted_string_escaper.sv =====
`default_nettype none

module tb_quoted_string_escaper;
  import qse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned NUM_DIRECTED = 22;

  // Directed row. When has_seq is set, the expected output is typed in seq
  // (right-justified, first byte highest), otherwise the predictor decides.
  typedef struct packed {
    logic [7:0]  ch;
    logic        first;
    logic        last;
    logic        nochar;
    logic        has_seq;
    logic [2:0]  seq_len;
    logic [47:0] seq;
  } text_row_t;

  typedef struct packed {
    logic        has_seq;
    logic [2:0]  seq_len;
    logic [47:0] seq;
  } item_note_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } escaped_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic [1:0] in_tuser;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;

  escaped_byte_t escaped_q[$];
  item_note_t    note_q[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_taken = 0;
  int unsigned bytes_checked = 0;
  int unsigned strings_sent = 0;
  int unsigned noise_sent = 0;
  int unsigned input_stall_cycles = 0;

  string hex_digits = "0123456789abcdef";

  text_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    '{8'h41, 1'b1, 1'b1, 1'b1, 1'b1, 3'd2, "\"\""},
    '{8'h5A, 1'b0, 1'b0, 1'b1, 1'b1, 3'd0, 48'd0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 3'd6, "\"\\x00\""},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 3'd6, "\"\\xff\""},
    '{8'h20, 1'b1, 1'b0, 1'b0, 1'b1, 3'd2, "\" "},
    '{8'h7E, 1'b0, 1'b0, 1'b0, 1'b1, 3'd1, "~"},
    '{8'h7F, 1'b0, 1'b0, 1'b0, 1'b1, 3'd4, "\\x7f"},
    '{8'h1F, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 48'd0},
    '{8'h80, 1'b0, 1'b1, 1'b0, 1'b1, 3'd5, "\\x80\""},
    '{CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0, 48'd0},
    '{CH_QUOTE, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 48'd0},
    '{CH_NL, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 48'd0},
    '{CH_CR, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 48'd0},
    '{CH_TAB, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 48'd0},
    '{CH_BEL, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 48'd0},
    '{CH_BS, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 48'd0},
    '{8'h41, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 48'd0},
    '{8'h42, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0, 48'd0},
    '{8'h43, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0, 48'd0},
    '{8'hA5, 1'b0, 1'b1, 1'b1, 1'b0, 3'd0, 48'd0},
    '{8'h5A, 1'b0, 1'b1, 1'b1, 1'b0, 3'd0, 48'd0},
    '{8'hC3, 1'b1, 1'b0, 1'b1, 1'b0, 3'd0, 48'd0}
  };

  quoted_string_escaper i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Appends the quoted, escaped bytes that one string item produces.
  function automatic void predict_escaped(input logic [7:0] ch, input logic first,
                                          input logic last, input logic nochar);
    logic [7:0] seq_b [0:5];
    int         n;
    n = 0;
    if (first) begin
      seq_b[n] = CH_QUOTE;
      n++;
    end
    if (!nochar) begin
      case (ch)
        CH_BSLASH, CH_QUOTE: begin
          seq_b[n] = CH_BSLASH;
          seq_b[n+1] = ch;
          n += 2;
        end
        CH_NL: begin
          seq_b[n] = CH_BSLASH;
          seq_b[n+1] = CH_LC_N;
          n += 2;
        end
        CH_CR: begin
          seq_b[n] = CH_BSLASH;
          seq_b[n+1] = CH_LC_R;
          n += 2;
        end
        CH_TAB: begin
          seq_b[n] = CH_BSLASH;
          seq_b[n+1] = CH_LC_T;
          n += 2;
        end
        CH_BEL: begin
          seq_b[n] = CH_BSLASH;
          seq_b[n+1] = CH_LC_A;
          n += 2;
        end
        CH_BS: begin
          seq_b[n] = CH_BSLASH;
          seq_b[n+1] = CH_LC_B;
          n += 2;
        end
        default: begin
          if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
            seq_b[n] = ch;
            n++;
          end else begin
            seq_b[n] = CH_BSLASH;
            seq_b[n+1] = CH_LC_X;
            seq_b[n+2] = hex_digits[ch[7:4]];
            seq_b[n+3] = hex_digits[ch[3:0]];
            n += 4;
          end
        end
      endcase
    end
    if (last) begin
      seq_b[n] = CH_QUOTE;
      n++;
    end
    for (int k = 0; k < n; k++) begin
      escaped_q.push_back('{out_byte: seq_b[k], last_of_run: (k == n - 1)});
    end
  endfunction

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] specials [0:6];
    specials = '{CH_BSLASH, CH_QUOTE, CH_NL, CH_CR, CH_TAB, CH_BEL, CH_BS};
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 8'($urandom_range(32'h7E, 32'h20));
      6: return specials[$urandom_range(6)];
      7: return 8'($urandom_range(32'h1F));
      8: return 8'($urandom_range(32'hFF, 32'h80));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  always @(posedge clk) begin
    escaped_byte_t exp_b;
    item_note_t    note;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("Regression FAIL");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        bytes_checked++;
        if (escaped_q.size() == 0) begin
          $error("Result with nothing expected: out_byte %h out_tlast %b", out_tdata, out_tlast);
          error_count++;
        end else begin
          exp_b = escaped_q.pop_front();
          if (out_tdata !== exp_b.out_byte) begin
            $error("out_byte: expected %h, actual %h", exp_b.out_byte, out_tdata);
            error_count++;
          end
          if (out_tlast !== exp_b.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", exp_b.last_of_run, out_tlast);
            error_count++;
          end
        end
      end
      if (in_tvalid && !in_tready) begin
        input_stall_cycles++;
      end
      if (in_tvalid && in_tready) begin
        items_taken++;
        note = note_q.pop_front();
        if (note.has_seq) begin
          for (int k = 0; k < note.seq_len; k++) begin
            escaped_q.push_back('{out_byte: note.seq[8*(note.seq_len-1-k) +: 8],
                                  last_of_run: (k == note.seq_len - 1)});
          end
        end else begin
          predict_escaped(in_tdata, in_tuser[0], in_tlast, in_tuser[1]);
        end
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        hold_count++;
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [7:0] ch, input logic first, input logic last,
                           input logic nochar, input logic has_seq = 1'b0,
                           input logic [2:0] seq_len = 3'd0, input logic [47:0] seq = 48'd0);
    note_q.push_back('{has_seq: has_seq, seq_len: seq_len, seq: seq});
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= {nochar, first};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    logic [2:0]  flags;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(4) == 0) begin
        flags = 3'($urandom_range(7));
        send_item(8'($urandom_range(255)), flags[0], flags[1], flags[2]);
        noise_sent++;
        if (!flags[2] || flags[0] || flags[1]) begin
          sent++;
        end
      end else begin
        len = $urandom_range(8);
        strings_sent++;
        if (len == 0) begin
          send_item(8'($urandom_range(255)), 1'b1, 1'b1, 1'b1);
          sent++;
        end else begin
          for (int k = 0; k < len; k++) begin
            send_item(pick_text_byte(), (k == 0), (k == len - 1), 1'b0);
          end
          sent += len;
        end
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = 2'b00;
    in_tlast  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle_pct = 29;
    rx_idle_pct = 65;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].ch, directed_rows[i].first, directed_rows[i].last,
                directed_rows[i].nochar, directed_rows[i].has_seq,
                directed_rows[i].seq_len, directed_rows[i].seq);
    end
    send_random(25);

    tx_idle_pct = 65;
    rx_idle_pct = 29;
    send_random(25);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    send_random(25);
    in_tvalid <= 1'b0;

    while (escaped_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items in %0d strings plus %0d noise items, %0d result bytes checked.",
             items_taken, strings_sent, noise_sent, bytes_checked);
    $display("Receiver held off %0d time(s); input was stalled for %0d cycles.",
             hold_count, input_stall_cycles);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
